### hw/rtl/imsp_pkg.sv
// Shared types and widths for the inverse map second partials unit.
// No dependencies; imported by the top level and imsp_div (imsp_wmul does not use it).
`default_nettype none

package imsp_pkg;

    // Pipeline control that travels with each request
    typedef struct packed {
        logic vld;
        logic sing;
    } t_ctl;

    // Input and intermediate widths (all signed)
    localparam int W_X  = 32;   // input derivative
    localparam int W_P  = 64;   // product of two derivatives
    localparam int W_D  = 65;   // Jacobian determinant
    localparam int W_C  = 66;   // quadratic form coefficient
    localparam int W_T  = W_C + W_X;   // one second-derivative term
    localparam int W_S  = W_T + 2;     // sum of three terms
    localparam int W_M  = W_S + W_X;   // S times a first derivative
    localparam int W_Q  = W_M + 1;     // second partial numerator
    localparam int W_D2 = 2 * W_D;
    localparam int W_D3 = 3 * W_D;
    localparam int W_NA = W_X + 1;     // first partial numerator

    // Result format and divider shape
    localparam int Q_W       = 32;
    localparam int Q_BITS    = Q_W + 1;     // quotient bits incl. overflow bit
    localparam int DIV_STEPS = Q_BITS;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int FRONT_LAT = 10;

    localparam logic [Q_W:0] LIM_POS = {2'b00, {(Q_W-1){1'b1}}};
    localparam logic [Q_W:0] LIM_NEG = {2'b01, {(Q_W-1){1'b0}}};

    // First derivative indexes
    localparam int FD_XU = 0;
    localparam int FD_YU = 1;
    localparam int FD_XV = 2;
    localparam int FD_YV = 3;

    // Second derivative terms and coordinates
    localparam int T_UU = 0;
    localparam int T_UV = 1;
    localparam int T_VV = 2;
    localparam int G_X  = 0;
    localparam int G_Y  = 1;
    localparam int ROWS = 3;

endpackage

`default_nettype wire

### hw/rtl/inverse_map_second_partials_unit.sv
// Top level: first and second partials of the inverse of a 2D patch map.
// Throughput: one request per clock; busy stays low, nothing ever stalls.
// Cost is set by the multiply stages and a 33-step restoring divider pipeline.
// Reset (synchronous, active low) clears all valid bits, so requests in flight are dropped.
// Depends on imsp_pkg, imsp_wmul and imsp_div.
`default_nettype none

module inverse_map_second_partials_unit import imsp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic signed [W_X-1:0] i_pos_du_x,
    input  wire logic signed [W_X-1:0] i_pos_du_y,
    input  wire logic signed [W_X-1:0] i_pos_dv_x,
    input  wire logic signed [W_X-1:0] i_pos_dv_y,
    input  wire logic signed [W_X-1:0] i_pos_duu_x,
    input  wire logic signed [W_X-1:0] i_pos_duu_y,
    input  wire logic signed [W_X-1:0] i_pos_dvv_x,
    input  wire logic signed [W_X-1:0] i_pos_dvv_y,
    input  wire logic signed [W_X-1:0] i_pos_duv_x,
    input  wire logic signed [W_X-1:0] i_pos_duv_y,
    output logic                       o_valid,
    output logic signed [Q_W-1:0]      o_inv_r0_c0,
    output logic signed [Q_W-1:0]      o_inv_r0_c1,
    output logic signed [Q_W-1:0]      o_inv_r1_c0,
    output logic signed [Q_W-1:0]      o_inv_r1_c1,
    output logic signed [Q_W-1:0]      o_inv_r2_c0,
    output logic signed [Q_W-1:0]      o_inv_r2_c1,
    output logic signed [Q_W-1:0]      o_inv_r3_c0,
    output logic signed [Q_W-1:0]      o_inv_r3_c1,
    output logic signed [Q_W-1:0]      o_inv_r4_c0,
    output logic signed [Q_W-1:0]      o_inv_r4_c1,
    output logic                       o_singular
);

    localparam int LAT = FRONT_LAT + DIV_LAT + 1;

    t_ctl                   r_ctl [FRONT_LAT+1];
    logic signed [W_X-1:0]  r_fd  [FRONT_LAT+1][4];
    logic signed [W_X-1:0]  r_x   [3][2][3];

    logic signed [W_P-1:0]  r_p_xuyv, r_p_yuxv, r_p_yvyv, r_p_yuyu, r_p_yvyu;
    logic signed [W_P-1:0]  r_p_xvxv, r_p_xuxu, r_p_xvxu, r_p_yvxv, r_p_yuxu;
    logic signed [W_P-1:0]  r_p_yvxu;

    logic signed [W_D-1:0]  n_det;
    logic signed [W_D-1:0]  r_det [2:FRONT_LAT];
    logic signed [W_C-1:0]  r_c   [ROWS][3];

    logic signed [W_T-1:0]  w_term [ROWS][2][3];
    logic signed [W_S-1:0]  r_s    [ROWS][2];
    logic signed [W_D2-1:0] w_d2;
    logic signed [W_D3-1:0] w_d3;
    logic signed [W_D3-1:0] r_d3 [9:FRONT_LAT];
    logic signed [W_M-1:0]  w_m  [ROWS][4];
    logic signed [W_Q-1:0]  r_q  [ROWS][2];

    logic signed [W_NA-1:0] w_num_a [4];
    logic signed [W_Q-1:0]  w_num_b [2*ROWS];
    logic [Q_W-1:0]         w_qa [4];
    logic [Q_W-1:0]         w_qb [2*ROWS];
    t_ctl                   w_ctl_a;
    t_ctl                   w_ctl_b;

    // Never stall: one request per clock
    assign busy = 1'b0;

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= FRONT_LAT; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= '{vld: start && !busy, sing: 1'b0};
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= '{vld: r_ctl[1].vld, sing: (n_det == '0)};
            for (int s = 3; s <= FRONT_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Capture request and carry first derivatives down the pipe
    always_ff @(posedge i_clk) begin
        r_fd[0][FD_XU] <= i_pos_du_x;
        r_fd[0][FD_YU] <= i_pos_du_y;
        r_fd[0][FD_XV] <= i_pos_dv_x;
        r_fd[0][FD_YV] <= i_pos_dv_y;
        for (int s = 1; s <= FRONT_LAT; s++) begin
            r_fd[s] <= r_fd[s-1];
        end
        r_x[0][G_X][T_UU] <= i_pos_duu_x;
        r_x[0][G_Y][T_UU] <= i_pos_duu_y;
        r_x[0][G_X][T_UV] <= i_pos_duv_x;
        r_x[0][G_Y][T_UV] <= i_pos_duv_y;
        r_x[0][G_X][T_VV] <= i_pos_dvv_x;
        r_x[0][G_Y][T_VV] <= i_pos_dvv_y;
        r_x[1] <= r_x[0];
        r_x[2] <= r_x[1];
    end

    // Products of first derivatives
    always_ff @(posedge i_clk) begin
        r_p_xuyv <= r_fd[0][FD_XU] * r_fd[0][FD_YV];
        r_p_yuxv <= r_fd[0][FD_YU] * r_fd[0][FD_XV];
        r_p_yvyv <= r_fd[0][FD_YV] * r_fd[0][FD_YV];
        r_p_yuyu <= r_fd[0][FD_YU] * r_fd[0][FD_YU];
        r_p_yvyu <= r_fd[0][FD_YV] * r_fd[0][FD_YU];
        r_p_xvxv <= r_fd[0][FD_XV] * r_fd[0][FD_XV];
        r_p_xuxu <= r_fd[0][FD_XU] * r_fd[0][FD_XU];
        r_p_xvxu <= r_fd[0][FD_XV] * r_fd[0][FD_XU];
        r_p_yvxv <= r_fd[0][FD_YV] * r_fd[0][FD_XV];
        r_p_yuxu <= r_fd[0][FD_YU] * r_fd[0][FD_XU];
        r_p_yvxu <= r_fd[0][FD_YV] * r_fd[0][FD_XU];
    end

    // Determinant and quadratic form coefficients for each second-partial output row
    assign n_det = W_D'(r_p_xuyv) - W_D'(r_p_yuxv);

    always_ff @(posedge i_clk) begin
        r_det[2] <= n_det;
        for (int s = 3; s <= FRONT_LAT; s++) begin
            r_det[s] <= r_det[s-1];
        end
        r_c[0][T_UU] <= W_C'(r_p_yvyv);
        r_c[0][T_UV] <= -(W_C'(r_p_yvyu) <<< 1);
        r_c[0][T_VV] <= W_C'(r_p_yuyu);
        r_c[1][T_UU] <= W_C'(r_p_xvxv);
        r_c[1][T_UV] <= -(W_C'(r_p_xvxu) <<< 1);
        r_c[1][T_VV] <= W_C'(r_p_xuxu);
        r_c[2][T_UU] <= -W_C'(r_p_yvxv);
        r_c[2][T_UV] <= W_C'(r_p_yvxu) + W_C'(r_p_yuxv);
        r_c[2][T_VV] <= -W_C'(r_p_yuxu);
    end

    // Second derivative terms
    for (genvar k = 0; k < ROWS; k++) begin : g_row
        for (genvar g = 0; g < 2; g++) begin : g_crd
            for (genvar t = 0; t < 3; t++) begin : g_trm
                imsp_wmul #(.WA(W_C), .WB(W_X)) u_term (
                    .i_clk (i_clk),
                    .i_a   (r_c[k][t]),
                    .i_b   (r_x[2][g][t]),
                    .o_p   (w_term[k][g][t])
                );
            end
        end
    end

    // Determinant square and cube
    imsp_wmul #(.WA(W_D), .WB(W_D)) u_det2 (
        .i_clk (i_clk),
        .i_a   (r_det[2]),
        .i_b   (r_det[2]),
        .o_p   (w_d2)
    );

    imsp_wmul #(.WA(W_D2), .WB(W_D)) u_det3 (
        .i_clk (i_clk),
        .i_a   (w_d2),
        .i_b   (r_det[5]),
        .o_p   (w_d3)
    );

    always_ff @(posedge i_clk) begin
        r_d3[9]  <= w_d3;
        r_d3[10] <= r_d3[9];
    end

    // Sum terms into S per row and coordinate
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROWS; k++) begin
            for (int g = 0; g < 2; g++) begin
                r_s[k][g] <= W_S'(w_term[k][g][T_UU]) + W_S'(w_term[k][g][T_UV])
                           + W_S'(w_term[k][g][T_VV]);
            end
        end
    end

    // Apply the inverse Jacobian numerators to S
    for (genvar k = 0; k < ROWS; k++) begin : g_kmul
        imsp_wmul #(.WA(W_S), .WB(W_X)) u_yv_sx (
            .i_clk (i_clk), .i_a (r_s[k][G_X]), .i_b (r_fd[6][FD_YV]), .o_p (w_m[k][0])
        );
        imsp_wmul #(.WA(W_S), .WB(W_X)) u_xv_sy (
            .i_clk (i_clk), .i_a (r_s[k][G_Y]), .i_b (r_fd[6][FD_XV]), .o_p (w_m[k][1])
        );
        imsp_wmul #(.WA(W_S), .WB(W_X)) u_xu_sy (
            .i_clk (i_clk), .i_a (r_s[k][G_Y]), .i_b (r_fd[6][FD_XU]), .o_p (w_m[k][2])
        );
        imsp_wmul #(.WA(W_S), .WB(W_X)) u_yu_sx (
            .i_clk (i_clk), .i_a (r_s[k][G_X]), .i_b (r_fd[6][FD_YU]), .o_p (w_m[k][3])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROWS; k++) begin
            r_q[k][0] <= W_Q'(w_m[k][1]) - W_Q'(w_m[k][0]);
            r_q[k][1] <= W_Q'(w_m[k][3]) - W_Q'(w_m[k][2]);
        end
    end

    // Divider operands
    always_comb begin
        w_num_a[0] = W_NA'(r_fd[FRONT_LAT][FD_YV]);
        w_num_a[1] = -W_NA'(r_fd[FRONT_LAT][FD_YU]);
        w_num_a[2] = -W_NA'(r_fd[FRONT_LAT][FD_XV]);
        w_num_a[3] = W_NA'(r_fd[FRONT_LAT][FD_XU]);
        for (int k = 0; k < ROWS; k++) begin
            w_num_b[2*k]   = r_q[k][0];
            w_num_b[2*k+1] = r_q[k][1];
        end
    end

    imsp_div #(.LANES(4), .NUM_W(W_NA), .DEN_W(W_D), .SH(2*FRAC_BITS)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl[FRONT_LAT]),
        .i_num   (w_num_a),
        .i_den   (r_det[FRONT_LAT]),
        .o_ctl   (w_ctl_a),
        .o_quo   (w_qa)
    );

    imsp_div #(.LANES(2*ROWS), .NUM_W(W_Q), .DEN_W(W_D3), .SH(3*FRAC_BITS)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl[FRONT_LAT]),
        .i_num   (w_num_b),
        .i_den   (r_d3[FRONT_LAT]),
        .o_ctl   (w_ctl_b),
        .o_quo   (w_qb)
    );

    // Drive result ports
    assign o_valid     = w_ctl_a.vld;
    assign o_singular  = w_ctl_a.sing;
    assign o_inv_r0_c0 = w_qa[0];
    assign o_inv_r0_c1 = w_qa[1];
    assign o_inv_r1_c0 = w_qa[2];
    assign o_inv_r1_c1 = w_qa[3];
    assign o_inv_r2_c0 = w_qb[0];
    assign o_inv_r2_c1 = w_qb[1];
    assign o_inv_r3_c0 = w_qb[2];
    assign o_inv_r3_c1 = w_qb[3];
    assign o_inv_r4_c0 = w_qb[4];
    assign o_inv_r4_c1 = w_qb[5];

    // Both divider pipes must stay in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl_a == w_ctl_b)
        else $error("divider pipes out of step");

    // Every accepted request yields a result after the fixed latency
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request produced no result");

    // No result without a request
    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without request");

    // Singular results carry zeros
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_inv_r0_c0 == '0 && o_inv_r0_c1 == '0
            && o_inv_r1_c0 == '0 && o_inv_r1_c1 == '0 && o_inv_r2_c0 == '0
            && o_inv_r2_c1 == '0 && o_inv_r3_c0 == '0 && o_inv_r3_c1 == '0
            && o_inv_r4_c0 == '0 && o_inv_r4_c1 == '0))
        else $error("singular result not zero");

endmodule

`default_nettype wire

### hw/rtl/imsp_wmul.sv
// Pipelined wide signed multiplier built from 33x33 partial products.
// Three register stages: partial products, row sums, final sum. No package use.
`default_nettype none

module imsp_wmul #(
    parameter int WA = 66,
    parameter int WB = 32
) (
    input  wire logic                  i_clk,
    input  wire logic signed [WA-1:0]  i_a,
    input  wire logic signed [WB-1:0]  i_b,
    output logic signed [WA+WB-1:0]    o_p
);

    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int WP = WA + WB;

    logic signed [32:0] w_ca [NA];
    logic signed [32:0] w_cb [NB];
    logic signed [65:0] r_pp [NA][NB];
    logic signed [WP-1:0] n_row [NB];
    logic signed [WP-1:0] r_row [NB];
    logic signed [WP-1:0] n_p;
    logic signed [WP-1:0] r_p;

    // Split operands into unsigned low chunks and a signed top chunk
    for (genvar i = 0; i < NA; i++) begin : g_ca
        if (i < NA - 1) begin : g_lo
            assign w_ca[i] = $signed({1'b0, i_a[32*i+31 -: 32]});
        end else begin : g_hi
            assign w_ca[i] = 33'($signed(i_a[WA-1:32*i]));
        end
    end
    for (genvar k = 0; k < NB; k++) begin : g_cb
        if (k < NB - 1) begin : g_lo
            assign w_cb[k] = $signed({1'b0, i_b[32*k+31 -: 32]});
        end else begin : g_hi
            assign w_cb[k] = 33'($signed(i_b[WB-1:32*k]));
        end
    end

    // Register partial products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            for (int k = 0; k < NB; k++) begin
                r_pp[i][k] <= w_ca[i] * w_cb[k];
            end
        end
    end

    // Sum each row of partial products
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            n_row[k] = '0;
            for (int i = 0; i < NA; i++) begin
                n_row[k] = n_row[k] + (WP'(r_pp[i][k]) <<< (32 * i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    // Combine rows
    always_comb begin
        n_p = '0;
        for (int k = 0; k < NB; k++) begin
            n_p = n_p + (r_row[k] <<< (32 * k));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### hw/rtl/imsp_div.sv
// Pipelined restoring divider, several numerator lanes over one divisor.
// One quotient bit per stage, then round to nearest and saturate. Uses imsp_pkg.
`default_nettype none

module imsp_div import imsp_pkg::*; #(
    parameter int LANES = 4,
    parameter int NUM_W = 33,
    parameter int DEN_W = 65,
    parameter int SH    = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctl                     i_ctl,
    input  wire logic signed [NUM_W-1:0]  i_num [LANES],
    input  wire logic signed [DEN_W-1:0]  i_den,
    output t_ctl                          o_ctl,
    output logic [Q_W-1:0]                o_quo [LANES]
);

    localparam int RW = NUM_W + SH;
    localparam int CW = ((RW > DEN_W + Q_BITS) ? RW : DEN_W + Q_BITS) + 2;
    localparam int NS = DIV_STEPS;

    logic [RW-1:0]     r_rem [NS+1][LANES];
    logic [Q_BITS-1:0] r_quo [NS+1][LANES];
    logic              r_neg [NS+1][LANES];
    logic [DEN_W-1:0]  r_dm  [NS+1];
    t_ctl              r_ctl [NS+1];

    logic [NUM_W-1:0]  w_nmag [LANES];
    logic [DEN_W-1:0]  w_dmag;
    logic              w_rnd  [LANES];
    logic [Q_W:0]      w_mag  [LANES];
    logic [Q_W:0]      w_lim  [LANES];
    logic [Q_W-1:0]    n_out  [LANES];
    logic [Q_W-1:0]    r_out  [LANES];
    t_ctl              r_octl;

    // Take magnitudes and signs
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_nmag[l] = i_num[l][NUM_W-1] ? NUM_W'(-i_num[l]) : NUM_W'(i_num[l]);
        end
        w_dmag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
        for (int l = 0; l < LANES; l++) begin
            r_neg[0][l] <= i_num[l][NUM_W-1] ^ i_den[DEN_W-1];
            r_rem[0][l] <= RW'(w_nmag[l]) << SH;
            r_quo[0][l] <= '0;
        end
        r_dm[0] <= w_dmag;
    end

    // One quotient bit per stage, overflow bit first
    for (genvar s = 1; s <= NS; s++) begin : g_step
        localparam int B = NS - s;
        logic [CW-1:0]    w_trial;
        logic [LANES-1:0] w_fit;

        always_comb begin
            w_trial = CW'(r_dm[s-1]) << B;
            for (int l = 0; l < LANES; l++) begin
                w_fit[l] = CW'(r_rem[s-1][l]) >= w_trial;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s] <= '0;
            end else begin
                r_ctl[s] <= r_ctl[s-1];
            end
            r_dm[s] <= r_dm[s-1];
            for (int l = 0; l < LANES; l++) begin
                r_neg[s][l] <= r_neg[s-1][l];
                if (w_fit[l]) begin
                    r_rem[s][l] <= RW'(CW'(r_rem[s-1][l]) - w_trial);
                    r_quo[s][l] <= r_quo[s-1][l] | (Q_BITS'(1) << B);
                end else begin
                    r_rem[s][l] <= r_rem[s-1][l];
                    r_quo[s][l] <= r_quo[s-1][l];
                end
            end
        end
    end

    // Round half away from zero, saturate, apply sign, zero when singular
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rnd[l] = (CW'(r_rem[NS][l]) << 1) >= CW'(r_dm[NS]);
            w_lim[l] = r_neg[NS][l] ? LIM_NEG : LIM_POS;
            w_mag[l] = {1'b0, r_quo[NS][l][Q_W-1:0]} + (Q_W+1)'(w_rnd[l]);
            if (r_quo[NS][l][Q_W] || (w_mag[l] > w_lim[l])) begin
                w_mag[l] = w_lim[l];
            end
            if (r_ctl[NS].sing) begin
                n_out[l] = '0;
            end else if (r_neg[NS][l]) begin
                n_out[l] = Q_W'(-w_mag[l]);
            end else begin
                n_out[l] = w_mag[l][Q_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octl <= '0;
        end else begin
            r_octl <= r_ctl[NS];
        end
        r_out <= n_out;
    end

    assign o_ctl = r_octl;
    assign o_quo = r_out;

endmodule

`default_nettype wire
